// ----- sv/pbfs_pkg.sv -----
// Shared constants and types of the packed bit field store.
`default_nettype none

package pbfs_pkg;

   // Storage geometry.
   localparam int WORD_BITS  = 64;
   localparam int WORD_COUNT = 256;
   localparam int STORE_BITS = WORD_BITS * WORD_COUNT;
   localparam int SHIFT_BITS = $clog2(WORD_BITS);
   localparam int ADDR_BITS  = $clog2(WORD_COUNT);

   // Field widths of the ports.
   localparam int POS_BITS   = 15;
   localparam int WIDTH_BITS = 7;
   localparam int MAX_FIELD  = 64;

   // Reset value of the capacity register.
   localparam logic [POS_BITS-1:0] CAP_RESET = POS_BITS'(16384);

   // Operation codes of a request.
   typedef enum logic {
      FUNC_APPEND = 1'b0,
      FUNC_READ   = 1'b1
   } func_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WR2,
      ST_RD1,
      ST_RD2
   } state_type;

endpackage

`default_nettype wire

// ----- sv/pbfs_ram.sv -----
// Generic single-port synchronous RAM with a registered read port.
`default_nettype none

module pbfs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One access per cycle: a write, or a read whose data shows up next cycle.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/packed_bit_field_store.sv -----
// Top level of the packed bit field store: sequencer, tail word and result register.
`default_nettype none

// Bit-packed store of 256 words of 64 bits, filled from bit 0 upward. An append
// request ORs a field of 0 to 64 bits in at the fill level and advances it; a
// read request returns the field at a given bit position, right aligned. The
// words sit in one single-port RAM with a registered read port. An append runs
// the execute state, a read the execute and first read states; a request that
// spans two words also runs a second write or read state (two RAM writes or
// reads). A request that is refused or has width zero ends in the execute state.
// The partly filled word at the fill level is also kept in a register, so an
// append never reads the RAM. No clearing pass is needed after reset: only words
// below the fill level are ever used. The capacity register takes a write in every
// cycle and should be written only while no request is in work.
module packed_bit_field_store (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [14:0] csr_capacity_bits,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_func,
   input  wire logic [6:0]  req_field_width,
   input  wire logic [63:0] req_append_value,
   input  wire logic [14:0] req_read_position,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_ok,
   output logic [63:0]      rsp_read_value,
   output logic [14:0]      rsp_fill_after
);

   localparam int WB = pbfs_pkg::WORD_BITS;
   localparam int SB = pbfs_pkg::SHIFT_BITS;
   localparam int AB = pbfs_pkg::ADDR_BITS;
   localparam int PB = pbfs_pkg::POS_BITS;
   localparam int WD = pbfs_pkg::WIDTH_BITS;

   pbfs_pkg::state_type state_ff, state_in;

   // Held request.
   pbfs_pkg::func_type  func_ff;
   logic [WD-1:0]       width_ff;
   logic [WB-1:0]       value_ff;
   logic [PB-1:0]       pos_ff;

   // Store state outside the RAM.
   logic [PB-1:0]       cap_ff;
   logic [PB-1:0]       fill_ff, fill_in;
   logic [WB-1:0]       tail_ff, tail_in;
   logic [WB-1:0]       low_word_ff;

   // Result register.
   logic                rsp_valid_ff;
   logic                rsp_ok_ff;
   logic [WB-1:0]       rsp_value_ff;
   logic [PB-1:0]       rsp_fill_ff;

   // RAM port.
   logic                ram_en;
   logic                ram_we;
   logic [AB-1:0]       ram_addr;
   logic [WB-1:0]       ram_wr_data;
   logic [WB-1:0]       ram_rd_data;

   // Sequencer outputs.
   logic                finish;
   logic                commit;
   logic                res_ok;
   logic [WB-1:0]       res_value;
   logic                latch_low;
   logic                out_free;

   // Datapath terms.
   logic                width_ok;
   logic [WB-1:0]       field_mask;
   logic [WB-1:0]       masked;
   logic [SB-1:0]       fill_sh;
   logic [PB-SB-1:0]    fill_word;
   logic [PB:0]         fill_sum;
   logic [PB-1:0]       eff_cap;
   logic                ap_ok;
   logic                ap_cross;
   logic [WB-1:0]       ap_low;
   logic [WB-1:0]       ap_high;
   logic [SB-1:0]       rd_sh;
   logic [PB-SB-1:0]    rd_word;
   logic [PB:0]         rd_end;
   logic                rd_ok;
   logic                rd_cross;
   logic                width_zero;

   pbfs_ram #(
      .WIDTH(WB),
      .DEPTH(pbfs_pkg::WORD_COUNT)
   ) u_ram (
      .clock   (clock),
      .en      (ram_en),
      .we      (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == pbfs_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Field mask and alignment terms for an append.
   always_comb begin
      width_ok   = (width_ff <= WD'(pbfs_pkg::MAX_FIELD));
      width_zero = (width_ff == '0);
      field_mask = ~({WB{1'b1}} << width_ff);
      masked     = value_ff & field_mask;
      fill_sh    = fill_ff[SB-1:0];
      fill_word  = fill_ff[PB-1:SB];
      fill_sum   = {1'b0, fill_ff} + (PB+1)'(width_ff);
      eff_cap    = (cap_ff < PB'(pbfs_pkg::STORE_BITS)) ? cap_ff : PB'(pbfs_pkg::STORE_BITS);
      ap_ok      = width_ok && (fill_sum <= {1'b0, eff_cap});
      ap_cross   = ((SB+2)'(fill_sh) + (SB+2)'(width_ff)) > (SB+2)'(WB);
      ap_low     = masked << fill_sh;
      ap_high    = masked >> (WD'(WB) - WD'(fill_sh));
   end

   // Alignment terms for a read.
   always_comb begin
      rd_sh    = pos_ff[SB-1:0];
      rd_word  = pos_ff[PB-1:SB];
      rd_end   = {1'b0, pos_ff} + (PB+1)'(width_ff);
      rd_ok    = width_ok && (rd_end <= {1'b0, fill_ff});
      rd_cross = ((SB+2)'(rd_sh) + (SB+2)'(width_ff)) > (SB+2)'(WB);
   end

   // Fill level and tail word after a committed append.
   always_comb begin
      fill_in = fill_sum[PB-1:0];
      if (fill_sum[SB-1:0] == '0) begin
         tail_in = '0;
      end else if (ap_cross) begin
         tail_in = ap_high;
      end else begin
         tail_in = tail_ff | ap_low;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pbfs_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = pbfs_pkg::ST_EXEC;
            end
         end
         pbfs_pkg::ST_EXEC: begin
            if (func_ff == pbfs_pkg::FUNC_APPEND) begin
               if (ap_ok && ap_cross) begin
                  state_in = pbfs_pkg::ST_WR2;
               end else if (out_free) begin
                  state_in = pbfs_pkg::ST_IDLE;
               end
            end else begin
               if (rd_ok && !width_zero) begin
                  state_in = pbfs_pkg::ST_RD1;
               end else if (out_free) begin
                  state_in = pbfs_pkg::ST_IDLE;
               end
            end
         end
         pbfs_pkg::ST_WR2: begin
            if (out_free) begin
               state_in = pbfs_pkg::ST_IDLE;
            end
         end
         pbfs_pkg::ST_RD1: begin
            if (rd_cross) begin
               state_in = pbfs_pkg::ST_RD2;
            end else if (out_free) begin
               state_in = pbfs_pkg::ST_IDLE;
            end
         end
         pbfs_pkg::ST_RD2: begin
            if (out_free) begin
               state_in = pbfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pbfs_pkg::ST_IDLE;
         end
      endcase
   end

   // RAM accesses and result of each state. A finishing state that finds the
   // result register busy does nothing and tries again next cycle.
   always_comb begin
      ram_en      = 1'b0;
      ram_we      = 1'b0;
      ram_addr    = fill_word[AB-1:0];
      ram_wr_data = tail_ff | ap_low;
      finish      = 1'b0;
      commit      = 1'b0;
      res_ok      = 1'b0;
      res_value   = '0;
      latch_low   = 1'b0;
      case (state_ff)
         pbfs_pkg::ST_EXEC: begin
            if (func_ff == pbfs_pkg::FUNC_APPEND) begin
               if (ap_ok && ap_cross) begin
                  ram_en = 1'b1;
                  ram_we = 1'b1;
               end else begin
                  ram_en = out_free && ap_ok && !width_zero;
                  ram_we = ram_en;
                  finish = out_free;
                  commit = out_free && ap_ok;
                  res_ok = ap_ok;
               end
            end else begin
               ram_addr = rd_word[AB-1:0];
               if (rd_ok && !width_zero) begin
                  ram_en = 1'b1;
               end else begin
                  finish = out_free;
                  res_ok = rd_ok;
               end
            end
         end
         pbfs_pkg::ST_WR2: begin
            ram_addr    = fill_word[AB-1:0] + AB'(1);
            ram_wr_data = ap_high;
            ram_en      = out_free;
            ram_we      = out_free;
            finish      = out_free;
            commit      = out_free;
            res_ok      = 1'b1;
         end
         pbfs_pkg::ST_RD1: begin
            ram_addr = rd_word[AB-1:0] + AB'(1);
            if (rd_cross) begin
               ram_en    = 1'b1;
               latch_low = 1'b1;
            end else begin
               finish    = out_free;
               res_ok    = 1'b1;
               res_value = (ram_rd_data >> rd_sh) & field_mask;
            end
         end
         pbfs_pkg::ST_RD2: begin
            finish    = out_free;
            res_ok    = 1'b1;
            res_value = ((low_word_ff >> rd_sh) |
                         (ram_rd_data << (WD'(WB) - WD'(rd_sh)))) & field_mask;
         end
         default: begin
            finish = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbfs_pkg::ST_IDLE;
         cap_ff       <= pbfs_pkg::CAP_RESET;
         fill_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_capacity_bits;
         end
         if (commit) begin
            fill_ff <= fill_in;
            tail_ff <= tail_in;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request, low word and result payload.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff  <= pbfs_pkg::func_type'(req_func);
         width_ff <= req_field_width;
         value_ff <= req_append_value;
         pos_ff   <= req_read_position;
      end
      if (latch_low) begin
         low_word_ff <= ram_rd_data;
      end
      if (finish) begin
         rsp_ok_ff    <= res_ok;
         rsp_value_ff <= res_value;
         rsp_fill_ff  <= commit ? fill_in : fill_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_fill_after = rsp_fill_ff;

   // The fill level never goes down.
   a_fill_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> fill_ff >= $past(fill_ff))
      else $error("fill level decreased");

   // The fill level stays within the storage.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= PB'(pbfs_pkg::STORE_BITS))
      else $error("fill level beyond storage");

   // A word-aligned fill level has an empty tail word.
   a_tail_clear: assert property (@(posedge clock) disable iff (reset)
      fill_ff[SB-1:0] == '0 |-> tail_ff == '0)
      else $error("tail word not clear at word boundary");

   // The RAM is written only by an append.
   a_write_append: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> func_ff == pbfs_pkg::FUNC_APPEND &&
                 (state_ff == pbfs_pkg::ST_EXEC || state_ff == pbfs_pkg::ST_WR2))
      else $error("RAM written outside an append");

   // A change of fill level comes with a result.
   a_fill_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && fill_ff != $past(fill_ff) |-> rsp_valid_ff)
      else $error("fill level changed without a result");

endmodule

`default_nettype wire
